FILE: sv/id3ts_pkg.sv
// Types, codes and frame id table for the ID3v2 tag frame splitter.
`timescale 1ns / 1ps
package id3ts_pkg;

    typedef logic [1:0] kind_t;
    typedef logic [3:0] class_t;

    localparam kind_t KIND_FRAME_START = 2'd0;
    localparam kind_t KIND_PAYLOAD     = 2'd1;
    localparam kind_t KIND_TAG_END     = 2'd2;
    localparam kind_t KIND_VERSION_ERR = 2'd3;

    localparam class_t CLASS_ETCO    = 4'd0;
    localparam class_t CLASS_TEXT    = 4'd1;
    localparam class_t CLASS_URL     = 4'd2;
    localparam class_t CLASS_WXXX    = 4'd3;
    localparam class_t CLASS_USLT    = 4'd4;
    localparam class_t CLASS_SYLT    = 4'd5;
    localparam class_t CLASS_COMM    = 4'd6;
    localparam class_t CLASS_RVA2    = 4'd7;
    localparam class_t CLASS_EQU2    = 4'd8;
    localparam class_t CLASS_RVRB    = 4'd9;
    localparam class_t CLASS_PCNT    = 4'd10;
    localparam class_t CLASS_POPM    = 4'd11;
    localparam class_t CLASS_RBUF    = 4'd12;
    localparam class_t CLASS_UNKNOWN = 4'd13;

    localparam logic [31:0] ID_ETCO = "ETCO";
    localparam logic [31:0] ID_WXXX = "WXXX";
    localparam logic [31:0] ID_USLT = "USLT";
    localparam logic [31:0] ID_SYLT = "SYLT";
    localparam logic [31:0] ID_COMM = "COMM";
    localparam logic [31:0] ID_RVA2 = "RVA2";
    localparam logic [31:0] ID_EQU2 = "EQU2";
    localparam logic [31:0] ID_RVRB = "RVRB";
    localparam logic [31:0] ID_PCNT = "PCNT";
    localparam logic [31:0] ID_POPM = "POPM";
    localparam logic [31:0] ID_RBUF = "RBUF";
    localparam logic [7:0]  CHAR_T  = "T";
    localparam logic [7:0]  CHAR_W  = "W";

    localparam logic [7:0] TAG_FLAG_EXT    = 8'd64;
    localparam logic [7:0] TAG_FLAG_FOOTER = 8'd16;
    localparam logic [27:0] FOOTER_LEN     = 28'd10;
    localparam logic [27:0] EXT_SIZE_LEN   = 28'd4;

    function automatic class_t classify(input logic [31:0] id);
        class_t c;
        c = CLASS_UNKNOWN;
        priority if (id == ID_ETCO)     c = CLASS_ETCO;
        else if (id[31:24] == CHAR_T)   c = CLASS_TEXT;
        else if (id == ID_WXXX)         c = CLASS_WXXX;
        else if (id[31:24] == CHAR_W)   c = CLASS_URL;
        else if (id == ID_USLT)         c = CLASS_USLT;
        else if (id == ID_SYLT)         c = CLASS_SYLT;
        else if (id == ID_COMM)         c = CLASS_COMM;
        else if (id == ID_RVA2)         c = CLASS_RVA2;
        else if (id == ID_EQU2)         c = CLASS_EQU2;
        else if (id == ID_RVRB)         c = CLASS_RVRB;
        else if (id == ID_PCNT)         c = CLASS_PCNT;
        else if (id == ID_POPM)         c = CLASS_POPM;
        else if (id == ID_RBUF)         c = CLASS_RBUF;
        else                            c = CLASS_UNKNOWN;
        return c;
    endfunction

endpackage

FILE: sv/id3ts_byte_if.sv
// Input channel carrying one tag stream byte per item.
`timescale 1ns / 1ps
interface id3ts_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

FILE: sv/id3ts_result_if.sv
// Result channel carrying frame starts, payload bytes and tag events.
`timescale 1ns / 1ps
interface id3ts_result_if
    import id3ts_pkg::*;
;
    logic        valid;
    logic        ready;
    kind_t       kind;
    class_t      frame_class;
    logic [31:0] frame_ident;
    logic [27:0] frame_length;
    logic [15:0] frame_flag_bits;
    logic [7:0]  payload_byte;
    logic        last_of_frame;
    logic        tag_done;

    modport source (output valid, output kind, output frame_class, output frame_ident,
                    output frame_length, output frame_flag_bits, output payload_byte,
                    output last_of_frame, output tag_done, input ready);
    modport sink   (input valid, input kind, input frame_class, input frame_ident,
                    input frame_length, input frame_flag_bits, input payload_byte,
                    input last_of_frame, input tag_done, output ready);
endinterface

FILE: sv/id3v2_tag_frame_splitter_unit.sv
// Top level: byte-serial ID3v2 tag header, extended header and frame splitter.
//
//  channel  | dir | handshake     | payload
//  stream   | in  | valid / ready | data_byte, restart
//  result   | out | valid / ready | kind, frame_class, frame_ident, frame_length,
//           |     |               | frame_flag_bits, payload_byte, last_of_frame, tag_done
//  cfg      | in  | cfg_write_en  | cfg_write_data (expected version)
//
// One byte per cycle unless stalled; each byte gives zero or one result the next cycle.
// The parse state updates in the accepting cycle; the result register is the only stage.
// A byte is taken while the result register is empty or being drained.
// rst_n clears parse state and sets the expected version to 4; no clearing pass.
`timescale 1ns / 1ps
module id3v2_tag_frame_splitter_unit
    import id3ts_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_en,
    input  logic [7:0]             cfg_write_data,
    id3ts_byte_if.sink             stream,
    id3ts_result_if.source         result
);

    localparam logic [2:0] PH_TAG_HDR   = 3'd0;
    localparam logic [2:0] PH_EXT_SIZE  = 3'd1;
    localparam logic [2:0] PH_EXT_SKIP  = 3'd2;
    localparam logic [2:0] PH_FRAME_HDR = 3'd3;
    localparam logic [2:0] PH_PAYLOAD   = 3'd4;
    localparam logic [2:0] PH_SKIP      = 3'd5;
    localparam logic [2:0] PH_IDLE      = 3'd6;

    logic [7:0]  expected_version_reg;
    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  header_index_reg, header_index_next;
    logic [7:0]  tag_flag_bits_reg, tag_flag_bits_next;
    logic [27:0] tag_remaining_reg, tag_remaining_next;
    logic [27:0] ext_remaining_reg, ext_remaining_next;
    logic [31:0] ident_shift_reg, ident_shift_next;
    logic [27:0] size_accum_reg, size_accum_next;
    logic [15:0] flags_accum_reg, flags_accum_next;
    logic [27:0] payload_remaining_reg, payload_remaining_next;
    class_t      current_class_reg, current_class_next;

    logic [2:0]  cur_phase;
    logic [3:0]  cur_index;
    logic [7:0]  cur_tag_flags;
    logic [27:0] cur_tag_rem;
    logic [27:0] cur_ext_rem;
    logic [31:0] cur_ident;
    logic [27:0] cur_size;
    logic [15:0] cur_flags;
    logic [27:0] cur_pay_rem;
    class_t      cur_class;

    logic        out_valid_reg;
    kind_t       kind_reg, kind_next;
    class_t      frame_class_reg, frame_class_next;
    logic [31:0] frame_ident_reg, frame_ident_next;
    logic [27:0] frame_length_reg, frame_length_next;
    logic [15:0] frame_flag_bits_reg, frame_flag_bits_next;
    logic [7:0]  payload_byte_reg, payload_byte_next;
    logic        last_of_frame_reg, last_of_frame_next;
    logic        tag_done_reg, tag_done_next;
    logic        res_valid;

    logic        accept;
    logic [7:0]  b;
    logic [27:0] size_shifted;
    logic [27:0] hdr_tag_rem;
    logic [27:0] ext_tag_rem;
    logic [27:0] ext_skip;
    logic [27:0] skip_dec;
    logic [27:0] body_tag_rem;
    logic [27:0] pay_dec;
    class_t      new_class;

    assign stream.ready = !out_valid_reg || result.ready;
    assign accept       = stream.valid && stream.ready;
    assign b            = stream.data_byte;

    // a restart byte sees the cleared parse state
    always_comb
    begin
        if (stream.restart)
        begin
            cur_phase     = PH_TAG_HDR;
            cur_index     = 4'd0;
            cur_tag_flags = 8'd0;
            cur_tag_rem   = 28'd0;
            cur_ext_rem   = 28'd0;
            cur_ident     = 32'd0;
            cur_size      = 28'd0;
            cur_flags     = 16'd0;
            cur_pay_rem   = 28'd0;
            cur_class     = CLASS_UNKNOWN;
        end
        else
        begin
            cur_phase     = phase_reg;
            cur_index     = header_index_reg;
            cur_tag_flags = tag_flag_bits_reg;
            cur_tag_rem   = tag_remaining_reg;
            cur_ext_rem   = ext_remaining_reg;
            cur_ident     = ident_shift_reg;
            cur_size      = size_accum_reg;
            cur_flags     = flags_accum_reg;
            cur_pay_rem   = payload_remaining_reg;
            cur_class     = current_class_reg;
        end
    end

    assign size_shifted = {cur_size[20:0], b[6:0]};
    assign hdr_tag_rem  = ((cur_tag_flags & TAG_FLAG_FOOTER) != 8'd0)
                        ? ((size_shifted >= FOOTER_LEN) ? size_shifted - FOOTER_LEN : 28'd0)
                        : size_shifted;
    assign ext_tag_rem  = (cur_tag_rem >= size_shifted) ? cur_tag_rem - size_shifted : 28'd0;
    assign ext_skip     = (size_shifted >= EXT_SIZE_LEN) ? size_shifted - EXT_SIZE_LEN : 28'd0;
    assign skip_dec     = (cur_ext_rem != 28'd0) ? cur_ext_rem - 28'd1 : 28'd0;
    assign body_tag_rem = (cur_tag_rem != 28'd0) ? cur_tag_rem - 28'd1 : 28'd0;
    assign pay_dec      = (cur_pay_rem != 28'd0) ? cur_pay_rem - 28'd1 : 28'd0;
    assign new_class    = classify(cur_ident);

    always_comb
    begin
        phase_next             = cur_phase;
        header_index_next      = cur_index;
        tag_flag_bits_next     = cur_tag_flags;
        tag_remaining_next     = cur_tag_rem;
        ext_remaining_next     = cur_ext_rem;
        ident_shift_next       = cur_ident;
        size_accum_next        = cur_size;
        flags_accum_next       = cur_flags;
        payload_remaining_next = cur_pay_rem;
        current_class_next     = cur_class;

        res_valid            = 1'b0;
        kind_next            = KIND_TAG_END;
        frame_class_next     = CLASS_ETCO;
        frame_ident_next     = 32'd0;
        frame_length_next    = 28'd0;
        frame_flag_bits_next = 16'd0;
        payload_byte_next    = 8'd0;
        last_of_frame_next   = 1'b0;
        tag_done_next        = 1'b0;

        unique case (cur_phase)
            PH_TAG_HDR:
            begin
                if (cur_index == 4'd3 && b != expected_version_reg)
                begin
                    phase_next = PH_IDLE;
                    res_valid  = 1'b1;
                    kind_next  = KIND_VERSION_ERR;
                end
                else if (cur_index < 4'd9)
                begin
                    if (cur_index == 4'd5)
                        tag_flag_bits_next = b;
                    if (cur_index >= 4'd6)
                        size_accum_next = size_shifted;
                    header_index_next = cur_index + 4'd1;
                end
                else
                begin
                    tag_remaining_next = hdr_tag_rem;
                    size_accum_next    = 28'd0;
                    header_index_next  = 4'd0;
                    if ((cur_tag_flags & TAG_FLAG_EXT) != 8'd0)
                        phase_next = PH_EXT_SIZE;
                    else if (hdr_tag_rem == 28'd0)
                    begin
                        phase_next    = PH_IDLE;
                        res_valid     = 1'b1;
                        tag_done_next = 1'b1;
                    end
                    else
                        phase_next = PH_FRAME_HDR;
                end
            end
            PH_EXT_SIZE:
            begin
                size_accum_next = size_shifted;
                if (cur_index < 4'd3)
                    header_index_next = cur_index + 4'd1;
                else
                begin
                    ext_remaining_next = ext_skip;
                    tag_remaining_next = ext_tag_rem;
                    size_accum_next    = 28'd0;
                    header_index_next  = 4'd0;
                    if (ext_skip != 28'd0)
                        phase_next = PH_EXT_SKIP;
                    else if (ext_tag_rem == 28'd0)
                    begin
                        phase_next    = PH_IDLE;
                        res_valid     = 1'b1;
                        tag_done_next = 1'b1;
                    end
                    else
                        phase_next = PH_FRAME_HDR;
                end
            end
            PH_EXT_SKIP:
            begin
                ext_remaining_next = skip_dec;
                if (skip_dec == 28'd0)
                begin
                    header_index_next = 4'd0;
                    if (cur_tag_rem == 28'd0)
                    begin
                        phase_next    = PH_IDLE;
                        res_valid     = 1'b1;
                        tag_done_next = 1'b1;
                    end
                    else
                        phase_next = PH_FRAME_HDR;
                end
            end
            PH_FRAME_HDR, PH_PAYLOAD, PH_SKIP:
            begin
                tag_remaining_next = body_tag_rem;
                if (cur_phase == PH_FRAME_HDR)
                begin
                    if (cur_index == 4'd0 && b == 8'd0)
                    begin
                        res_valid     = 1'b1;
                        tag_done_next = 1'b1;
                    end
                    else if (cur_index < 4'd4)
                    begin
                        ident_shift_next  = {cur_ident[23:0], b};
                        header_index_next = cur_index + 4'd1;
                    end
                    else if (cur_index < 4'd8)
                    begin
                        size_accum_next   = size_shifted;
                        header_index_next = cur_index + 4'd1;
                    end
                    else if (cur_index < 4'd9)
                    begin
                        flags_accum_next  = {cur_flags[7:0], b};
                        header_index_next = cur_index + 4'd1;
                    end
                    else
                    begin
                        flags_accum_next       = {cur_flags[7:0], b};
                        header_index_next      = 4'd0;
                        current_class_next     = new_class;
                        payload_remaining_next = cur_size;
                        res_valid              = 1'b1;
                        kind_next              = KIND_FRAME_START;
                        frame_class_next       = new_class;
                        frame_ident_next       = cur_ident;
                        frame_length_next      = cur_size;
                        frame_flag_bits_next   = {cur_flags[7:0], b};
                        if (cur_size == 28'd0)
                            phase_next = PH_FRAME_HDR;
                        else if (new_class == CLASS_UNKNOWN)
                            phase_next = PH_SKIP;
                        else
                            phase_next = PH_PAYLOAD;
                    end
                end
                else
                begin
                    payload_remaining_next = pay_dec;
                    if (cur_phase == PH_PAYLOAD)
                    begin
                        res_valid            = 1'b1;
                        kind_next            = KIND_PAYLOAD;
                        frame_class_next     = cur_class;
                        frame_ident_next     = cur_ident;
                        frame_length_next    = cur_size;
                        frame_flag_bits_next = cur_flags;
                        payload_byte_next    = b;
                        last_of_frame_next   = (pay_dec == 28'd0);
                    end
                    if (pay_dec == 28'd0)
                        phase_next = PH_FRAME_HDR;
                end
                // body exhausted or padding: close the tag
                if (body_tag_rem == 28'd0 || (cur_phase == PH_FRAME_HDR && cur_index == 4'd0
                                              && b == 8'd0))
                begin
                    phase_next    = PH_IDLE;
                    tag_done_next = 1'b1;
                    res_valid     = 1'b1;
                end
            end
            default:
            begin
                phase_next = cur_phase;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_version_reg  <= 8'd4;
            phase_reg             <= PH_TAG_HDR;
            header_index_reg      <= 4'd0;
            tag_flag_bits_reg     <= 8'd0;
            tag_remaining_reg     <= 28'd0;
            ext_remaining_reg     <= 28'd0;
            ident_shift_reg       <= 32'd0;
            size_accum_reg        <= 28'd0;
            flags_accum_reg       <= 16'd0;
            payload_remaining_reg <= 28'd0;
            current_class_reg     <= CLASS_UNKNOWN;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
                expected_version_reg <= cfg_write_data;
            if (accept)
            begin
                phase_reg             <= phase_next;
                header_index_reg      <= header_index_next;
                tag_flag_bits_reg     <= tag_flag_bits_next;
                tag_remaining_reg     <= tag_remaining_next;
                ext_remaining_reg     <= ext_remaining_next;
                ident_shift_reg       <= ident_shift_next;
                size_accum_reg        <= size_accum_next;
                flags_accum_reg       <= flags_accum_next;
                payload_remaining_reg <= payload_remaining_next;
                current_class_reg     <= current_class_next;
            end
            if (accept && res_valid)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
        begin
            kind_reg            <= kind_next;
            frame_class_reg     <= frame_class_next;
            frame_ident_reg     <= frame_ident_next;
            frame_length_reg    <= frame_length_next;
            frame_flag_bits_reg <= frame_flag_bits_next;
            payload_byte_reg    <= payload_byte_next;
            last_of_frame_reg   <= last_of_frame_next;
            tag_done_reg        <= tag_done_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.kind            = kind_reg;
    assign result.frame_class     = frame_class_reg;
    assign result.frame_ident     = frame_ident_reg;
    assign result.frame_length    = frame_length_reg;
    assign result.frame_flag_bits = frame_flag_bits_reg;
    assign result.payload_byte    = payload_byte_reg;
    assign result.last_of_frame   = last_of_frame_reg;
    assign result.tag_done        = tag_done_reg;

`ifndef SYNTHESIS
    a_end_closes_tag: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.kind == KIND_TAG_END |-> result.tag_done)
        else $error("tag end result without tag_done");

    a_last_only_on_payload: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.last_of_frame |-> result.kind == KIND_PAYLOAD)
        else $error("last_of_frame on a non-payload result");

    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res_valid && tag_done_next |=> phase_reg == PH_IDLE)
        else $error("parser not idle after closing the tag");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        header_index_reg <= 4'd9)
        else $error("header index out of range");
`endif

endmodule
